>>> src/rcsr_pkg.sv
// ----------------------------------------------------------------------------
// rcsr_pkg: shared types and constants for the RV64 CSR file
// CSR numbers, field masks, access codes and small helpers for the CSR views.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsr_pkg;

   // Store geometry
   localparam int CSR_SPACE_DEPTH = 4096;
   localparam int ADDR_W          = $clog2(CSR_SPACE_DEPTH);

   // Stream payload widths
   localparam int REQ_DATA_W = 272;
   localparam int RSP_DATA_W = 72;

   typedef logic [ADDR_W-1:0] csr_addr_type;
   typedef logic [63:0]       word_type;

   // Access codes
   localparam logic [1:0] OP_READ      = 2'd0;
   localparam logic [1:0] OP_WRITE     = 2'd1;
   localparam logic [1:0] OP_WRITE_CNT = 2'd2;

   // CSR numbers
   localparam csr_addr_type A_FFLAGS        = 12'h001;
   localparam csr_addr_type A_FRM           = 12'h002;
   localparam csr_addr_type A_FCSR          = 12'h003;
   localparam csr_addr_type A_SSTATUS       = 12'h100;
   localparam csr_addr_type A_SIE           = 12'h104;
   localparam csr_addr_type A_STVEC         = 12'h105;
   localparam csr_addr_type A_SCOUNTEREN    = 12'h106;
   localparam csr_addr_type A_SSCRATCH      = 12'h140;
   localparam csr_addr_type A_SEPC          = 12'h141;
   localparam csr_addr_type A_SCAUSE        = 12'h142;
   localparam csr_addr_type A_STVAL         = 12'h143;
   localparam csr_addr_type A_SIP           = 12'h144;
   localparam csr_addr_type A_STIMECMP      = 12'h14D;
   localparam csr_addr_type A_SATP          = 12'h180;
   localparam csr_addr_type A_MSTATUS       = 12'h300;
   localparam csr_addr_type A_MISA          = 12'h301;
   localparam csr_addr_type A_MEDELEG       = 12'h302;
   localparam csr_addr_type A_MIDELEG       = 12'h303;
   localparam csr_addr_type A_MIE           = 12'h304;
   localparam csr_addr_type A_MTVEC         = 12'h305;
   localparam csr_addr_type A_MCOUNTEREN    = 12'h306;
   localparam csr_addr_type A_MENVCFG       = 12'h30A;
   localparam csr_addr_type A_MCOUNTINHIBIT = 12'h320;
   localparam csr_addr_type A_MSCRATCH      = 12'h340;
   localparam csr_addr_type A_MEPC          = 12'h341;
   localparam csr_addr_type A_MCAUSE        = 12'h342;
   localparam csr_addr_type A_MTVAL         = 12'h343;
   localparam csr_addr_type A_MIP           = 12'h344;
   localparam csr_addr_type A_PMPCFG0       = 12'h3A0;
   localparam csr_addr_type A_PMPADDR0      = 12'h3B0;
   localparam csr_addr_type A_MCYCLE        = 12'hB00;
   localparam csr_addr_type A_MINSTRET      = 12'hB02;
   localparam csr_addr_type A_CYCLE         = 12'hC00;
   localparam csr_addr_type A_TIME          = 12'hC01;
   localparam csr_addr_type A_INSTRET       = 12'hC02;
   localparam csr_addr_type A_MHARTID       = 12'hF14;

   // Counter ranges
   localparam csr_addr_type A_HPM_LO      = 12'hC03;
   localparam csr_addr_type A_HPM_HI      = 12'hC1F;
   localparam csr_addr_type A_MHPM_LO     = 12'hB03;
   localparam csr_addr_type A_MHPM_HI     = 12'hB1F;
   localparam csr_addr_type A_MHPMEVT_LO  = 12'h323;
   localparam csr_addr_type A_MHPMEVT_HI  = 12'h33F;
   localparam csr_addr_type HPM_ALIAS_OFS = 12'h100;

   // Status fields
   localparam word_type ST_SD      = 64'h8000_0000_0000_0000;
   localparam word_type ST_S_VIEW  = 64'h0000_0000_000C_6722;
   localparam word_type ST_MPP     = 64'h0000_0000_0000_1800;

   // Interrupt masks
   localparam word_type IR_STI     = 64'h0000_0000_0000_0020;
   localparam word_type S_IRQ      = 64'h0000_0000_0000_0222;
   localparam word_type M_IRQ      = 64'h0000_0000_0000_0AAA;

   // Other masks and fixed values
   localparam word_type EDELEG_MASK = 64'h0000_0000_0000_B3AE;
   localparam word_type MISA_FIXED  = 64'h8000_0000_0014_1105;
   localparam word_type PPN_MASK    = 64'h0000_0FFF_FFFF_FFFF;
   localparam logic [3:0] SV39_MODE = 4'h8;

   // Set SD when FS or VS is dirty, clear it otherwise
   function automatic word_type sd_fold(input word_type v);
      word_type r;
      r = v;
      r[63] = (v[14:13] == 2'b11) || (v[10:9] == 2'b11);
      return r;
   endfunction

   // Drop the reserved MPP encoding, then recompute SD
   function automatic word_type legal_status(input word_type v);
      word_type r;
      r = v;
      if (v[12:11] == 2'b10) begin
         r[12:11] = 2'b00;
      end
      return sd_fold(r);
   endfunction

   // Map the user hpmcounter aliases onto the machine hpmcounters
   function automatic csr_addr_type store_index(input csr_addr_type a);
      csr_addr_type r;
      r = a;
      if ((a >= A_HPM_LO) && (a <= A_HPM_HI)) begin
         r = a - HPM_ALIAS_OFS;
      end
      return r;
   endfunction

   // Supported CSR set
   function automatic logic supported(input csr_addr_type a);
      logic r;
      r = ((a >= A_HPM_LO) && (a <= A_HPM_HI)) ||
          ((a >= A_MHPM_LO) && (a <= A_MHPM_HI)) ||
          ((a >= A_MHPMEVT_LO) && (a <= A_MHPMEVT_HI));
      case (a)
         A_SSTATUS, A_SIE, A_STVEC, A_SCOUNTEREN, A_SSCRATCH, A_SEPC, A_SCAUSE,
         A_STVAL, A_SIP, A_SATP, A_FFLAGS, A_FRM, A_FCSR, A_MSTATUS, A_MISA,
         A_MEDELEG, A_MIDELEG, A_MIE, A_MTVEC, A_MCOUNTEREN, A_MCOUNTINHIBIT,
         A_MENVCFG, A_PMPCFG0, A_PMPADDR0, A_MCYCLE, A_MINSTRET, A_MSCRATCH,
         A_MEPC, A_MCAUSE, A_MTVAL, A_MIP, A_MHARTID, A_CYCLE, A_TIME,
         A_INSTRET, A_STIMECMP: begin
            r = 1'b1;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/riscv_csr_register_file.sv
// ----------------------------------------------------------------------------
// riscv_csr_register_file: RV64 control and status register file
// One CSR read or write per request transfer, one response transfer each.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : request stream. tuser carries the access kind (read, write,
//            write that may set the core counters); tdata carries address,
//            write data and the live cycle, instret and timer values.
//   rsp_*  : response stream: read data and the implemented, TLB flush,
//            cycle-load and instret-load flags.
//   csr_*  : one-bit write channel selecting the time source (always ready).
// Timing
//   An accepted request waits in the read stage, then in the output register.
//   One request is taken per cycle while req_tready is high; the store is a
//   single-port read / single-port write memory read ahead of the update, and
//   a write followed directly by a read of the same entry is forwarded.
// Reset
//   After reset a clearing pass writes every one of the 4096 store entries
//   (misa gets its fixed value); req_tready stays low throughout.
// Back-pressure
//   A response waits in the output register while rsp_tready is low; one
//   further request is held in the read stage, then req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module riscv_csr_register_file (
   input  wire                               clock,
   input  wire                               reset,
   // Request stream
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // tdata: csr_address[11:0], write_data[75:12], cycle_count[139:76],
   //        instret_count[203:140], timer_value[267:204], zero pad
   input  wire  [rcsr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: op[1:0]
   input  wire  [1:0]                        req_tuser,
   // Response stream
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // tdata: read_data[63:0], implemented[64], tlb_flush[65], cycle_load[66],
   //        instret_load[67], zero pad
   output logic [rcsr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Configuration write channel: time_from_timer
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire                               csr_data
);
   import rcsr_pkg::*;

   // Handshakes
   logic req_accept;
   logic advance;

   // Configuration
   logic time_sel_ff;

   // Clearing pass
   logic         clr_busy_ff;
   csr_addr_type clr_addr_ff;

   // Store memory
   word_type     store_mem [CSR_SPACE_DEPTH];
   logic         mem_we;
   csr_addr_type mem_wa;
   word_type     mem_wd;
   word_type     mem_rd_ff;
   csr_addr_type req_index;

   // Read stage
   logic         s1_valid_ff;
   logic [1:0]   s1_op_ff;
   csr_addr_type s1_addr_ff;
   word_type     s1_wdata_ff;
   word_type     s1_cycle_ff;
   word_type     s1_instret_ff;
   word_type     s1_timer_ff;
   logic         fwd_valid_ff;
   word_type     fwd_data_ff;

   // Architectural registers kept outside the store; most feed views of several CSRs
   word_type   mstatus_ff,  mstatus_in;
   logic [7:0] fcsr_ff,     fcsr_in;
   word_type   medeleg_ff,  medeleg_in;
   word_type   mideleg_ff,  mideleg_in;
   word_type   mie_ff,      mie_in;
   word_type   mip_ff,      mip_in;
   logic       stce_ff,     stce_in;
   word_type   stimecmp_ff, stimecmp_in;

   // Stage results
   word_type     mem_word;
   word_type     now_val;
   logic         pending;
   logic         do_write;
   logic         s1_mem_we;
   word_type     s1_mem_wd;
   csr_addr_type s1_index;
   word_type     rd_val;
   word_type     irq_mask;
   logic         flush;
   logic         set_cyc;
   logic         set_ret;

   // Output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   // Handshakes
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || advance);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         time_sel_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         time_sel_ff <= csr_data;
      end
   end

   // Clearing pass: one entry per cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Memory port selection
   assign req_index = store_index(req_tdata[ADDR_W-1:0]);

   always_comb begin
      if (clr_busy_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = (clr_addr_ff == A_MISA) ? MISA_FIXED : '0;
      end else begin
         mem_we = advance && s1_mem_we;
         mem_wa = s1_index;
         mem_wd = s1_mem_wd;
      end
   end

   // Store memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      if (req_accept) begin
         mem_rd_ff <= store_mem[req_index];
      end
   end

   // Read stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Capture the request; forward a same-entry write that the read missed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff      <= req_tuser;
         s1_addr_ff    <= req_tdata[11:0];
         s1_wdata_ff   <= req_tdata[75:12];
         s1_cycle_ff   <= req_tdata[139:76];
         s1_instret_ff <= req_tdata[203:140];
         s1_timer_ff   <= req_tdata[267:204];
         fwd_valid_ff  <= advance && s1_mem_we && (s1_index == req_index);
         fwd_data_ff   <= s1_mem_wd;
      end
   end

   // Shared operands
   assign s1_index = store_index(s1_addr_ff);
   assign mem_word = fwd_valid_ff ? fwd_data_ff : mem_rd_ff;
   assign now_val  = time_sel_ff ? s1_timer_ff : s1_cycle_ff;
   assign pending  = stce_ff && (now_val >= stimecmp_ff);
   assign irq_mask = mideleg_ff & S_IRQ;
   assign do_write = (s1_op_ff == OP_WRITE) ||
                     ((s1_op_ff == OP_WRITE_CNT) && (s1_addr_ff != A_MCYCLE) &&
                      (s1_addr_ff != A_MINSTRET));
   assign set_cyc  = (s1_op_ff == OP_WRITE_CNT) && (s1_addr_ff == A_MCYCLE);
   assign set_ret  = (s1_op_ff == OP_WRITE_CNT) && (s1_addr_ff == A_MINSTRET);
   assign flush    = do_write && (s1_addr_ff == A_SATP);

   // Read views
   always_comb begin
      rd_val = mem_word;
      case (s1_addr_ff)
         A_CYCLE, A_MCYCLE: begin
            rd_val = s1_cycle_ff;
         end
         A_TIME: begin
            rd_val = now_val;
         end
         A_INSTRET, A_MINSTRET: begin
            rd_val = s1_instret_ff;
         end
         A_SSTATUS: begin
            rd_val = sd_fold(mstatus_ff) & (ST_S_VIEW | ST_SD);
         end
         A_FFLAGS: begin
            rd_val = {59'd0, fcsr_ff[4:0]};
         end
         A_FRM: begin
            rd_val = {61'd0, fcsr_ff[7:5]};
         end
         A_FCSR: begin
            rd_val = {56'd0, fcsr_ff};
         end
         A_MHARTID: begin
            rd_val = '0;
         end
         A_MEDELEG: begin
            rd_val = medeleg_ff;
         end
         A_MIDELEG: begin
            rd_val = mideleg_ff;
         end
         A_MIE: begin
            rd_val = mie_ff;
         end
         A_MIP: begin
            rd_val = mip_ff | (pending ? IR_STI : '0);
         end
         A_SIE: begin
            rd_val = mie_ff & irq_mask;
         end
         A_SIP: begin
            rd_val = (mip_ff & irq_mask) |
                     ((pending && (mideleg_ff[5] == 1'b1)) ? IR_STI : '0);
         end
         A_MENVCFG: begin
            rd_val = {stce_ff, 63'd0};
         end
         A_MSTATUS: begin
            rd_val = sd_fold(mstatus_ff);
         end
         A_STIMECMP: begin
            rd_val = stimecmp_ff;
         end
         default: begin
         end
      endcase
   end

   // Write rules: registers with views, or the store; read-only CSRs ignore writes
   always_comb begin
      mstatus_in  = mstatus_ff;
      fcsr_in     = fcsr_ff;
      medeleg_in  = medeleg_ff;
      mideleg_in  = mideleg_ff;
      mie_in      = mie_ff;
      mip_in      = mip_ff;
      stce_in     = stce_ff;
      stimecmp_in = stimecmp_ff;
      s1_mem_we   = 1'b0;
      s1_mem_wd   = s1_wdata_ff;
      if (do_write) begin
         case (s1_addr_ff)
            A_CYCLE, A_TIME, A_INSTRET, A_MCYCLE, A_MINSTRET, A_MISA, A_MHARTID: begin
            end
            A_SSTATUS: begin
               mstatus_in = legal_status((mstatus_ff & ~ST_S_VIEW) |
                                         (s1_wdata_ff & ST_S_VIEW));
            end
            A_FFLAGS: begin
               fcsr_in[4:0] = s1_wdata_ff[4:0];
            end
            A_FRM: begin
               fcsr_in[7:5] = s1_wdata_ff[2:0];
            end
            A_FCSR: begin
               fcsr_in = s1_wdata_ff[7:0];
            end
            A_MSTATUS: begin
               mstatus_in = legal_status(s1_wdata_ff);
            end
            A_SATP: begin
               s1_mem_we = 1'b1;
               s1_mem_wd = (s1_wdata_ff[63:60] == SV39_MODE) ?
                           ({SV39_MODE, 60'd0} | (s1_wdata_ff & PPN_MASK)) : '0;
            end
            A_MEDELEG: begin
               medeleg_in = s1_wdata_ff & EDELEG_MASK;
            end
            A_MIDELEG: begin
               mideleg_in = s1_wdata_ff & S_IRQ;
            end
            A_MIE: begin
               mie_in = s1_wdata_ff & M_IRQ;
            end
            A_MIP: begin
               mip_in = s1_wdata_ff & M_IRQ;
            end
            A_MENVCFG: begin
               stce_in = s1_wdata_ff[63];
            end
            A_SIE: begin
               mie_in = (mie_ff & ~irq_mask) | (s1_wdata_ff & irq_mask);
            end
            A_SIP: begin
               mip_in = (mip_ff & ~irq_mask) | (s1_wdata_ff & irq_mask);
            end
            A_STIMECMP: begin
               stimecmp_in = s1_wdata_ff;
            end
            default: begin
               s1_mem_we = 1'b1;
            end
         endcase
      end
   end

   // Commit register updates as the item leaves the read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         mstatus_ff  <= '0;
         fcsr_ff     <= '0;
         medeleg_ff  <= '0;
         mideleg_ff  <= '0;
         mie_ff      <= '0;
         mip_ff      <= '0;
         stce_ff     <= 1'b0;
         stimecmp_ff <= '1;
      end else if (advance) begin
         mstatus_ff  <= mstatus_in;
         fcsr_ff     <= fcsr_in;
         medeleg_ff  <= medeleg_in;
         mideleg_ff  <= mideleg_in;
         mie_ff      <= mie_in;
         mip_ff      <= mip_in;
         stce_ff     <= stce_in;
         stimecmp_ff <= stimecmp_in;
      end
   end

   // Pack the response
   assign rsp_data_in = {4'd0, set_ret, set_cyc, flush, supported(s1_addr_ff),
                         (s1_op_ff == OP_READ) ? rd_val : 64'd0};

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

>>> src/rcsr_checker.sv
// ----------------------------------------------------------------------------
// rcsr_checker: port-level checks for the RV64 CSR file
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsr_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tready,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [rcsr_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import rcsr_pkg::*;

   // Hold off requests as the clearing pass starts after reset
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during clearing pass");

   // At most one side effect per response
   a_one_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[67:65]))
      else $error("more than one side-effect flag set");

   // Side effects only on implemented CSRs and with zero read data
   a_effect_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[67:65] != 3'b000)) |->
      (rsp_tdata[64] && (rsp_tdata[63:0] == 64'd0)))
      else $error("side-effect flag with read data or unimplemented CSR");

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind riscv_csr_register_file rcsr_checker u_rcsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
